@@ rtl/texture_channel_to_float_defines.svh @@
// ----------------------------------------------------------------------------
// texture_channel_to_float_defines: assertion macros
// Shared property shorthands for the channel converter; clk and rst_n are
// taken from the scope where a macro is used.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_CHANNEL_TO_FLOAT_DEFINES_SVH
`define TEXTURE_CHANNEL_TO_FLOAT_DEFINES_SVH

// same-cycle implication
`define TCF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tcf_pkg.sv @@
// ----------------------------------------------------------------------------
// tcf_pkg: shared types and constants
// Stage payloads, channel type codes and fp32 patterns of the converter.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int PIXEL_WIDTH = 64;
    localparam int IN_TDATA_W  = ((PIXEL_WIDTH + 7) / 8) * 8;
    localparam int FIELD_W     = 32;
    localparam int OUT_TDATA_W = 32;

    // fp32 patterns
    localparam logic [31:0] QNAN_BITS    = 32'h7FC0_0000;
    localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
    localparam logic [31:0] NEG_ONE_BITS = 32'hBF80_0000;
    localparam logic [31:0] INF_BITS     = 32'h7F80_0000;

    // channel type codes
    typedef enum logic [2:0] {
        CH_UNORM  = 3'd0,
        CH_SNORM  = 3'd1,
        CH_SFLOAT = 3'd2,
        CH_UFLOAT = 3'd3,
        CH_UINT   = 3'd4
    } chan_type_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_OFFSET = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_TYPE   = 2'd2
    } reg_index_t;

    // after extraction
    typedef struct packed {
        logic [FIELD_W-1:0] field;
        logic [5:0]         width;
        logic [2:0]         ctype;
    } s1_t;

    // after classification
    typedef struct packed {
        logic        ratio;
        logic        sign;
        logic [23:0] num;
        logic [4:0]  m;
        logic [31:0] res;
        logic        bad;
    } s2_t;

    // ratio expansion stages
    typedef struct packed {
        logic        ratio;
        logic        sign;
        logic [31:0] word;
        logic [4:0]  m;
        logic [7:0]  exp;
        logic [31:0] res;
        logic        bad;
    } rep_t;

endpackage

@@ rtl/tcf_extract.sv @@
// ----------------------------------------------------------------------------
// tcf_extract: channel field extraction
// Shifts the pixel word down by the channel offset and masks to the width.
// ----------------------------------------------------------------------------
module tcf_extract (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tcf_pkg::PIXEL_WIDTH-1:0] pixel,
    input  logic [5:0]                    offset,
    input  logic [5:0]                    width,
    input  logic [2:0]                    ctype,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tcf_pkg::s1_t                  out_data
);

    logic                                              valid_reg;
    tcf_pkg::s1_t                                      data_reg;
    tcf_pkg::s1_t                                      data_next;
    logic [tcf_pkg::PIXEL_WIDTH+tcf_pkg::FIELD_W-1:0]  ext;
    logic [tcf_pkg::PIXEL_WIDTH+tcf_pkg::FIELD_W-1:0]  shifted;
    logic [tcf_pkg::FIELD_W:0]                         mask_wide;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // bits above the pixel read as zero; widths past the field keep all bits
    always_comb
    begin
        ext       = {{tcf_pkg::FIELD_W{1'b0}}, pixel};
        shifted   = ext >> offset;
        mask_wide = ({{tcf_pkg::FIELD_W{1'b0}}, 1'b1} << width) - 1'b1;
        data_next.field = shifted[tcf_pkg::FIELD_W-1:0] & mask_wide[tcf_pkg::FIELD_W-1:0];
        data_next.width = width;
        data_next.ctype = ctype;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

@@ rtl/tcf_classify.sv @@
// ----------------------------------------------------------------------------
// tcf_classify: type decode and direct conversions
// Resolves float types, zero, one and clamp cases; hands the remaining
// normalized fractions on as numerator and period length.
// ----------------------------------------------------------------------------
module tcf_classify (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  tcf_pkg::s1_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output tcf_pkg::s2_t out_data
);

    logic          valid_reg;
    tcf_pkg::s2_t  data_reg;
    tcf_pkg::s2_t  data_next;
    logic [31:0]   v;
    logic [5:0]    n;
    logic          norm_ok;
    logic [24:0]   field25;
    logic [24:0]   pow_n;
    logic [24:0]   d_u;
    logic [24:0]   d_s;
    logic [24:0]   mag;
    logic          neg;

    // small float with 5-bit exponent, mantissa left-aligned to 10 bits
    function automatic logic [31:0] small_to_fp32(input logic sgn, input logic [4:0] e,
                                                  input logic [9:0] m10);
        logic [3:0]  p;
        logic [32:0] sh;
        logic [31:0] r;
        p  = 4'd0;
        sh = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (m10[i])
                p = 4'(i);
        end
        if (e == 5'd0)
        begin
            if (m10 == 10'd0)
                r = {sgn, 31'd0};
            else
            begin
                sh = {23'd0, m10} << (5'd23 - {1'b0, p});
                r  = {sgn, 8'd103 + {4'd0, p}, sh[22:0]};
            end
        end
        else if (e != 5'd31)
            r = {sgn, {3'd0, e} + 8'd112, m10, 13'd0};
        else if (m10 == 10'd0)
            r = {sgn, 31'd0} | tcf_pkg::INF_BITS;
        else
            r = tcf_pkg::QNAN_BITS;
        return r;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // shared terms of the normalized types
    always_comb
    begin
        v       = in_data.field;
        n       = in_data.width;
        norm_ok = (n != 6'd0) && (n <= 6'd24);
        field25 = v[24:0];
        pow_n   = 25'd1 << n;
        d_u     = pow_n - 25'd1;
        d_s     = (pow_n >> 1) - 25'd1;
        mag     = pow_n - field25;
        neg     = |(field25 & (pow_n >> 1));
    end

    // per-type decode
    always_comb
    begin
        data_next.ratio = 1'b0;
        data_next.sign  = 1'b0;
        data_next.num   = field25[23:0];
        data_next.m     = n[4:0];
        data_next.res   = tcf_pkg::QNAN_BITS;
        data_next.bad   = 1'b0;
        case (in_data.ctype)
            tcf_pkg::CH_UNORM:
            begin
                if (!norm_ok)
                    data_next.bad = 1'b1;
                else if (field25 == 25'd0)
                    data_next.res = 32'd0;
                else if (field25 >= d_u)
                    data_next.res = tcf_pkg::ONE_BITS;
                else
                    data_next.ratio = 1'b1;
            end
            tcf_pkg::CH_SNORM:
            begin
                data_next.m = n[4:0] - 5'd1;
                if (!norm_ok)
                    data_next.bad = 1'b1;
                else if (neg)
                begin
                    data_next.num = mag[23:0];
                    if (mag >= d_s)
                        data_next.res = tcf_pkg::NEG_ONE_BITS;
                    else
                    begin
                        data_next.ratio = 1'b1;
                        data_next.sign  = 1'b1;
                    end
                end
                else if (field25 == 25'd0)
                    data_next.res = 32'd0;
                else if (field25 >= d_s)
                    data_next.res = tcf_pkg::ONE_BITS;
                else
                    data_next.ratio = 1'b1;
            end
            tcf_pkg::CH_SFLOAT:
            begin
                if (n == 6'd32)
                begin
                    if ((&v[30:23]) && (|v[22:0]))
                        data_next.res = tcf_pkg::QNAN_BITS;
                    else
                        data_next.res = v;
                end
                else if (n == 6'd16)
                    data_next.res = small_to_fp32(v[15], v[14:10], v[9:0]);
                else
                    data_next.bad = 1'b1;
            end
            tcf_pkg::CH_UFLOAT:
            begin
                if (n == 6'd11)
                    data_next.res = small_to_fp32(1'b0, v[10:6], {v[5:0], 4'd0});
                else if (n == 6'd10)
                    data_next.res = small_to_fp32(1'b0, v[9:5], {v[4:0], 5'd0});
                else
                    data_next.bad = 1'b1;
            end
            default:
                data_next.bad = 1'b1;
        endcase
        if (data_next.bad)
            data_next.res = tcf_pkg::QNAN_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

@@ rtl/tcf_ratio.sv @@
// ----------------------------------------------------------------------------
// tcf_ratio: repeating fraction expansion
// num / (2^m - 1) is the m-bit numerator repeated forever in binary. Three
// stages: normalize one period, then replicate it by doubling (m, 2m / 4m, 8m).
// ----------------------------------------------------------------------------
module tcf_ratio (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tcf_pkg::s2_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output tcf_pkg::rep_t out_data
);

    logic          v3_reg;
    logic          v4_reg;
    logic          v5_reg;
    logic          rdy3;
    logic          rdy4;
    logic          rdy5;
    tcf_pkg::rep_t d3_reg;
    tcf_pkg::rep_t d4_reg;
    tcf_pkg::rep_t d5_reg;
    tcf_pkg::rep_t d3_next;
    tcf_pkg::rep_t d4_next;
    tcf_pkg::rep_t d5_next;
    logic [4:0]    lz;
    logic [23:0]   period;
    logic [31:0]   y1;
    logic [31:0]   y3;

    assign rdy5      = !v5_reg || out_ready;
    assign rdy4      = !v4_reg || rdy5;
    assign rdy3      = !v3_reg || rdy4;
    assign in_ready  = rdy3;
    assign out_valid = v5_reg;
    assign out_data  = d5_reg;

    // stage 3: leading-one normalize, exponent from leading position
    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (in_data.num[i])
                lz = 5'(23 - i);
        end
        period        = in_data.num << lz;
        d3_next.ratio = in_data.ratio;
        d3_next.sign  = in_data.sign;
        d3_next.word  = {period, 8'd0};
        d3_next.m     = in_data.m;
        d3_next.exp   = 8'd150 - {3'd0, lz} - {3'd0, in_data.m};
        d3_next.res   = in_data.res;
        d3_next.bad   = in_data.bad;
    end

    // stage 4: copies at m and 2m
    always_comb
    begin
        d4_next      = d3_reg;
        y1           = d3_reg.word | (d3_reg.word >> d3_reg.m);
        d4_next.word = y1 | (y1 >> {d3_reg.m, 1'b0});
    end

    // stage 5: copies at 4m and 8m
    always_comb
    begin
        d5_next      = d4_reg;
        y3           = d4_reg.word | (d4_reg.word >> {d4_reg.m, 2'b0});
        d5_next.word = y3 | (y3 >> {d4_reg.m, 3'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
                v3_reg <= in_valid;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && in_valid)
            d3_reg <= d3_next;
        if (rdy4 && v3_reg)
            d4_reg <= d4_next;
        if (rdy5 && v4_reg)
            d5_reg <= d5_next;
    end

endmodule

@@ rtl/tcf_round.sv @@
// ----------------------------------------------------------------------------
// tcf_round: round and output register
// Rounds the 24-bit significand on its guard bit (the tail is never exact)
// and holds the result for the master side.
// ----------------------------------------------------------------------------
`include "texture_channel_to_float_defines.svh"

module tcf_round (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tcf_pkg::rep_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   float_bits,
    output logic          unsupported
);

    logic        valid_reg;
    logic [31:0] bits_reg;
    logic        bad_reg;
    logic [31:0] bits_next;
    logic [24:0] q;
    logic [7:0]  exp_r;
    logic [22:0] mant_r;

    assign in_ready    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign float_bits  = bits_reg;
    assign unsupported = bad_reg;

    // round to nearest, carry into exponent on significand overflow
    always_comb
    begin
        q      = {1'b0, in_data.word[31:8]} + {24'd0, in_data.word[7]};
        exp_r  = q[24] ? in_data.exp + 8'd1 : in_data.exp;
        mant_r = q[24] ? 23'd0 : q[22:0];
        bits_next = in_data.ratio ? {in_data.sign, exp_r, mant_r} : in_data.res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            bits_reg <= bits_next;
            bad_reg  <= in_data.bad;
        end
    end

    `TCF_ASSERT_NOW(a_ratio_normalized, in_valid && in_data.ratio, in_data.word[31], "ratio significand lost its leading one")
    `TCF_ASSERT_NOW(a_ratio_supported, in_valid && in_data.ratio, !in_data.bad, "ratio path taken for an unsupported channel")

endmodule

@@ rtl/texture_channel_to_float.sv @@
// ----------------------------------------------------------------------------
// texture_channel_to_float: texture channel to fp32 converter
// Extracts one channel from a pixel word and converts unorm, snorm, half,
// fp32 and small unsigned floats to an IEEE single precision pattern.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields
// s_axis    in   tdata: pixel_word[63:0]
// m_axis    out  tdata: float_bits[31:0]; tuser: unsupported[0]
// cfg       in   cfg_we, cfg_index (0 offset, 1 width, 2 type), cfg_wdata[5:0]
//
// One transaction per cycle while m_axis is not stalled; each item passes the register
// stages in order (extract, classify, normalize, replicate x2, round/output).
// Reset clears all stage valids; config resets to offset 0, width 8, unorm.
// A stall on m_axis backs up stage by stage; each stage keeps its item
// until the next one has room, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "texture_channel_to_float_defines.svh"

module texture_channel_to_float (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [tcf_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // pixel_word
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [tcf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // float_bits
    output logic [0:0]                     m_axis_tuser,   // unsupported
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [5:0]                     cfg_wdata
);

    logic [5:0]    chan_offset_reg;
    logic [5:0]    chan_width_reg;
    logic [2:0]    chan_type_reg;
    logic          v1;
    logic          r1;
    logic          v2;
    logic          r2;
    logic          v5;
    logic          r5;
    tcf_pkg::s1_t  d1;
    tcf_pkg::s2_t  d2;
    tcf_pkg::rep_t d5;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_offset_reg <= 6'd0;
            chan_width_reg  <= 6'd8;
            chan_type_reg   <= tcf_pkg::CH_UNORM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcf_pkg::REG_OFFSET: chan_offset_reg <= cfg_wdata;
                tcf_pkg::REG_WIDTH:  chan_width_reg  <= cfg_wdata;
                tcf_pkg::REG_TYPE:   chan_type_reg   <= cfg_wdata[2:0];
                default:             chan_offset_reg <= chan_offset_reg;
            endcase
        end
    end

    // pipeline
    tcf_extract u_extract (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pixel     (s_axis_tdata[tcf_pkg::PIXEL_WIDTH-1:0]),
        .offset    (chan_offset_reg),
        .width     (chan_width_reg),
        .ctype     (chan_type_reg),
        .out_valid (v1),
        .out_ready (r1),
        .out_data  (d1)
    );

    tcf_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_data   (d1),
        .out_valid (v2),
        .out_ready (r2),
        .out_data  (d2)
    );

    tcf_ratio u_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_data   (d2),
        .out_valid (v5),
        .out_ready (r5),
        .out_data  (d5)
    );

    tcf_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v5),
        .in_ready    (r5),
        .in_data     (d5),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .float_bits  (m_axis_tdata),
        .unsupported (m_axis_tuser[0])
    );

    `TCF_ASSERT_NOW(a_unsupported_is_nan, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == tcf_pkg::QNAN_BITS, "unsupported result is not the canonical NaN")

endmodule

@@ tb/tb_texture_channel_to_float.sv @@
// ----------------------------------------------------------------------------
// tb_texture_channel_to_float: self-checking bench for the channel converter
// Sends pixel words through s_axis under many channel settings and checks
// every m_axis transaction against a directed row or an in-bench fp32 conversion
// model. Both stream sides pause at random except in the closing stretch.
// ----------------------------------------------------------------------------
module tb_texture_channel_to_float;
    import tcf_pkg::*;

    localparam int RANDOM_ITEMS = 1450;

    typedef struct {
        logic [31:0] bits;
        logic        bad;
    } conv_result_t;

    typedef struct {
        logic [5:0]  offset;
        logic [5:0]  width;
        logic [2:0]  ctype;
        logic [63:0] pixel;
        bit          typed;  // expected value given in the row
        logic [31:0] bits;
        logic        bad;
    } pixel_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // pixel_word
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // float_bits
    logic [0:0]             m_axis_tuser;   // unsupported
    logic                   cfg_we;
    logic [1:0]             cfg_index;
    logic [5:0]             cfg_wdata;

    // current channel setting, as last written
    logic [5:0] cur_offset;
    logic [5:0] cur_width;
    logic [2:0] cur_type;

    conv_result_t pending_floats[$];
    int           error_count;
    bit           idling_on;
    int           stall_left;
    int           items_sent;

    texture_channel_to_float u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // correctly rounded fp32 of num/den, 0 < num < den < 2^24
    function automatic logic [31:0] ratio_float(logic [63:0] num, logic [63:0] den);
        int unsigned k;
        logic [63:0] scaled;
        logic [63:0] q;
        logic [63:0] r;
        k = 0;
        while (((num << k) < (den << 23)) && k < 60)
            k++;
        scaled = num << k;
        q = scaled / den;
        r = scaled % den;
        if ((2 * r > den) || ((2 * r == den) && q[0]))
            q++;
        if (q >= (64'd1 << 24))
        begin
            q = q >> 1;
            k--;
        end
        return {(9'd150 - k[8:0]), q[22:0]};
    endfunction

    // small float with 5-bit exponent, bias 15, mb mantissa bits
    function automatic logic [31:0] small_float(logic sgn, logic [4:0] e, logic [9:0] m,
                                                int unsigned mb);
        int unsigned lead;
        logic [31:0] frac;
        lead = 0;
        if (e == 5'd0)
        begin
            if (m == 10'd0)
                return {sgn, 31'd0};
            for (int i = 0; i < mb; i++)
                if (m[i])
                    lead = i;
            frac = (32'(m) - (32'd1 << lead)) << (23 - lead);
            return {sgn, 8'(127 + lead - 14 - mb), frac[22:0]};
        end
        if (e != 5'd31)
        begin
            frac = 32'(m) << (23 - mb);
            return {sgn, 8'(e + 112), frac[22:0]};
        end
        if (m == 10'd0)
            return {sgn, 31'd0} | INF_BITS;
        return QNAN_BITS;
    endfunction

    // expected conversion of one pixel under the current setting
    function automatic conv_result_t convert_channel(logic [63:0] pixel);
        conv_result_t res;
        logic [63:0]  field;
        logic [63:0]  den;
        logic [63:0]  mag;
        int unsigned  n;
        n = cur_width;
        field = (pixel >> cur_offset) & ((64'd1 << n) - 64'd1);
        res.bits = QNAN_BITS;
        res.bad = 1'b0;
        case (cur_type)
            CH_UNORM:
            begin
                if (n == 0 || n > 24)
                    res.bad = 1'b1;
                else
                begin
                    den = (64'd1 << n) - 64'd1;
                    if (field == 0)
                        res.bits = 32'd0;
                    else if (field >= den)
                        res.bits = ONE_BITS;
                    else
                        res.bits = ratio_float(field, den);
                end
            end
            CH_SNORM:
            begin
                if (n == 0 || n > 24)
                    res.bad = 1'b1;
                else
                begin
                    den = (64'd1 << (n - 1)) - 64'd1;
                    if (field[n-1])
                    begin
                        mag = (64'd1 << n) - field;
                        res.bits = (mag >= den) ? NEG_ONE_BITS
                                                : (32'h8000_0000 | ratio_float(mag, den));
                    end
                    else if (field == 0)
                        res.bits = 32'd0;
                    else if (field >= den)
                        res.bits = ONE_BITS;
                    else
                        res.bits = ratio_float(field, den);
                end
            end
            CH_SFLOAT:
            begin
                if (n == 32)
                    res.bits = (field[30:23] == 8'hFF && field[22:0] != 0) ? QNAN_BITS
                                                                            : field[31:0];
                else if (n == 16)
                    res.bits = small_float(field[15], field[14:10], field[9:0], 10);
                else
                    res.bad = 1'b1;
            end
            CH_UFLOAT:
            begin
                if (n == 11)
                    res.bits = small_float(1'b0, field[10:6], {4'd0, field[5:0]}, 6);
                else if (n == 10)
                    res.bits = small_float(1'b0, field[9:5], {5'd0, field[4:0]}, 5);
                else
                    res.bad = 1'b1;
            end
            default: res.bad = 1'b1;
        endcase
        if (res.bad)
            res.bits = QNAN_BITS;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // wait for the pipeline to drain, then rewrite all three registers
    task automatic set_channel(logic [5:0] offset, logic [5:0] width, logic [2:0] ctype);
        while (pending_floats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_OFFSET;
        cfg_wdata <= offset;
        @(posedge clk);
        cfg_index <= REG_WIDTH;
        cfg_wdata <= width;
        @(posedge clk);
        cfg_index <= REG_TYPE;
        cfg_wdata <= {3'd0, ctype};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_offset = offset;
        cur_width = width;
        cur_type = ctype;
    endtask

    // one s_axis transaction; the expectation is queued on acceptance
    task automatic send_pixel(logic [63:0] pixel, conv_result_t want);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pixel;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_floats.push_back(want);
        items_sent++;
    endtask

    // m_axis check and random back-pressure
    always @(posedge clk)
    begin
        conv_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_floats.size() == 0)
                    report_mismatch("unexpected result", m_axis_tdata, 32'd0);
                else
                begin
                    want = pending_floats.pop_front();
                    if (m_axis_tdata !== want.bits)
                        report_mismatch("float_bits", m_axis_tdata, want.bits);
                    if (m_axis_tuser[0] !== want.bad)
                        report_mismatch("unsupported", 32'(m_axis_tuser), 32'(want.bad));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // directed rows: reset setting, extremes, every type, special cases
    pixel_row_t rows[] = '{
        '{6'd0,  6'd8,  CH_UNORM,  64'h0,                  1, 32'h0,        0},
        '{6'd0,  6'd8,  CH_UNORM,  64'hFF,                 1, ONE_BITS,     0},
        '{6'd0,  6'd8,  CH_UNORM,  64'h80,                 0, 32'h0,        0},
        '{6'd60, 6'd8,  CH_UNORM,  64'hF000_0000_0000_0000, 0, 32'h0,       0},
        '{6'd63, 6'd1,  CH_UNORM,  64'h8000_0000_0000_0000, 1, ONE_BITS,    0},
        '{6'd3,  6'd3,  CH_UNORM,  64'hFFFF_FFFF_FFFF_FFD7, 0, 32'h0,       0},
        '{6'd0,  6'd24, CH_UNORM,  64'hFF_FFFF,            1, ONE_BITS,     0},
        '{6'd0,  6'd24, CH_UNORM,  64'h1,                  0, 32'h0,        0},
        '{6'd0,  6'd25, CH_UNORM,  64'h1,                  1, QNAN_BITS,    1},
        '{6'd0,  6'd8,  CH_SNORM,  64'h80,                 1, NEG_ONE_BITS, 0},
        '{6'd0,  6'd8,  CH_SNORM,  64'h81,                 1, NEG_ONE_BITS, 0},
        '{6'd0,  6'd8,  CH_SNORM,  64'h7F,                 1, ONE_BITS,     0},
        '{6'd0,  6'd1,  CH_SNORM,  64'h1,                  1, NEG_ONE_BITS, 0},
        '{6'd0,  6'd1,  CH_SNORM,  64'h0,                  1, 32'h0,        0},
        '{6'd5,  6'd16, CH_SNORM,  64'h20,                 0, 32'h0,        0},
        '{6'd0,  6'd32, CH_SFLOAT, 64'h7F80_0001,          1, QNAN_BITS,    0},
        '{6'd0,  6'd32, CH_SFLOAT, 64'hFFFF_FFFF,          1, QNAN_BITS,    0},
        '{6'd32, 6'd32, CH_SFLOAT, 64'hC000_0000_0000_0000, 1, 32'hC000_0000, 0},
        '{6'd0,  6'd16, CH_SFLOAT, 64'h7C00,               1, INF_BITS,     0},
        '{6'd0,  6'd16, CH_SFLOAT, 64'hFC01,               1, QNAN_BITS,    0},
        '{6'd0,  6'd16, CH_SFLOAT, 64'h8001,               0, 32'h0,        0},
        '{6'd0,  6'd8,  CH_SFLOAT, 64'h1,                  1, QNAN_BITS,    1},
        '{6'd0,  6'd11, CH_UFLOAT, 64'h7C0,                1, INF_BITS,     0},
        '{6'd0,  6'd10, CH_UFLOAT, 64'h3FF,                1, QNAN_BITS,    0},
        '{6'd0,  6'd32, CH_UINT,   64'h5,                  1, QNAN_BITS,    1},
        '{6'd0,  6'd8,  3'd7,      64'h5,                  1, QNAN_BITS,    1}
    };

    // stimulus
    initial
    begin
        conv_result_t want;
        logic [5:0]   w;
        logic [5:0]   o;
        logic [2:0]   t;
        logic [63:0]  pixel;
        int           phase_len;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_OFFSET;
        cfg_wdata = '0;
        error_count = 0;
        stall_left = 0;
        items_sent = 0;
        idling_on = 1'b1;
        cur_offset = 6'd0;
        cur_width = 6'd8;
        cur_type = CH_UNORM;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].offset != cur_offset || rows[i].width != cur_width
                || rows[i].ctype != cur_type)
            begin
                s_axis_tvalid <= 1'b0;
                set_channel(rows[i].offset, rows[i].width, rows[i].ctype);
            end
            if (rows[i].typed)
            begin
                want.bits = rows[i].bits;
                want.bad = rows[i].bad;
            end
            else
                want = convert_channel(rows[i].pixel);
            send_pixel(rows[i].pixel, want);
        end

        // random phases, each with its own channel setting
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            t = 3'($urandom_range(0, 9));
            if (t > 3'd4 && $urandom_range(0, 3) != 0)
                t = 3'($urandom_range(0, 3));
            case (t)
                CH_UNORM, CH_SNORM:
                    w = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(25, 32))
                                                    : 6'($urandom_range(1, 24));
                CH_SFLOAT:
                    w = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(1, 32))
                                                    : ($urandom_range(0, 1) ? 6'd16 : 6'd32);
                CH_UFLOAT:
                    w = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(1, 32))
                                                    : ($urandom_range(0, 1) ? 6'd10 : 6'd11);
                default: w = 6'($urandom_range(1, 32));
            endcase
            o = ($urandom_range(0, 5) == 0) ? 6'd63 : 6'($urandom_range(0, 63));
            s_axis_tvalid <= 1'b0;
            set_channel(o, w, t);
            if (items_sent > RANDOM_ITEMS - 200)
                idling_on = 1'b0;
            phase_len = $urandom_range(10, 60);
            repeat (phase_len)
            begin
                pixel = {$urandom, $urandom};
                case ($urandom_range(0, 7))
                    0: pixel = '0;
                    1: pixel = '1;
                    2: pixel = pixel & ~(((64'd1 << w) - 64'd1) << o);
                    3: pixel = pixel | (((64'd1 << w) - 64'd1) << o);
                    4: pixel = (pixel & ~(((64'd1 << w) - 64'd1) << o))
                               | (64'd1 << (o + w - 1)) | (64'd1 << o);
                    default: ;
                endcase
                send_pixel(pixel, convert_channel(pixel));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_floats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_floats.size() == 0)
            $display("tb_texture_channel_to_float: done, clean");
        else
            $display("tb_texture_channel_to_float: done, errors");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", pending_floats.size());
        $display("tb_texture_channel_to_float: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tcf_pkg.sv
rtl/tcf_extract.sv
rtl/tcf_classify.sv
rtl/tcf_ratio.sv
rtl/tcf_round.sv
rtl/texture_channel_to_float.sv
tb/tb_texture_channel_to_float.sv
